FILE: design/wsd_pkg.sv
// Package for the WebSocket frame deframer: parse phases, header constants
// and the word types of the request and response channels. No dependencies.
package wsd_pkg;

   typedef enum logic [2:0] {
      PH_HDR1    = 3'd0,
      PH_HDR2    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   // Seven-bit length codes that announce an extended length.
   localparam logic [6:0] LEN16_CODE = 7'd126;
   localparam logic [6:0] LEN64_CODE = 7'd127;

   // Header bytes still to take in a phase, minus one.
   localparam logic [2:0] LEN16_BYTES_M1 = 3'd1;
   localparam logic [2:0] LEN64_BYTES_M1 = 3'd7;
   localparam logic [2:0] KEY_BYTES_M1   = 3'd3;

   typedef struct packed {
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       fin_bit;
      logic [3:0] frame_opcode;
      logic       last_of_frame;
      logic       empty_frame;
   } rsp_word_type;

endpackage

FILE: design/wsd_if.sv
// Valid/ready channel interfaces for the deframer's request and response words.
// Depends on wsd_pkg for the word types.
interface wsd_req_if;
   import wsd_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface wsd_rsp_if;
   import wsd_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: design/websocket_frame_deframer.sv
// WebSocket frame deframer: parses back-to-back frames from a byte stream and
// returns unmasked payload bytes. Depends on wsd_pkg and the wsd_if interfaces.
// Throughput: one byte per cycle, sustained, while the response side takes words.
// A response word appears in the cycle after the payload byte (or the final
// header byte of an empty frame) is accepted. Header bytes give no word.
// Reset is synchronous and active high; it returns the parser to header byte one.
module websocket_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   wsd_req_if.sink    req_chan,
   wsd_rsp_if.source  rsp_chan
);
   import wsd_pkg::*;

   // Parser state. Only the phase is control state; the rest is always
   // written by the header before it is used, so it needs no reset.
   phase_type    phase_ff, phase_in;
   logic         fin_ff, fin_in;
   logic [3:0]   opcode_ff, opcode_in;
   logic         masked_ff, masked_in;
   logic [63:0]  remaining_ff, remaining_in;
   logic [2:0]   hdr_count_ff, hdr_count_in;
   logic [31:0]  key_ff, key_in;
   logic [1:0]   key_index_ff, key_index_in;

   // Output register, which parts the response side from the parser.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic         accept;
   logic         emit;
   logic [7:0]   in_byte;
   logic [63:0]  ext_len;
   logic [7:0]   key_byte;
   logic [7:0]   res_byte;
   logic         res_last;
   logic         res_empty;

   // A new byte is taken whenever the output register is free or is being
   // drained in this same cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_byte        = req_chan.payload.data_byte;

   // Extended length shifts in big-endian, one byte per accepted word.
   assign ext_len = {remaining_ff[55:0], in_byte};

   // The key is stored first byte most significant; payload byte n uses key byte n mod 4.
   always_comb begin
      case (key_index_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      fin_in       = fin_ff;
      opcode_in    = opcode_ff;
      masked_in    = masked_ff;
      remaining_in = remaining_ff;
      hdr_count_in = hdr_count_ff;
      key_in       = key_ff;
      key_index_in = key_index_ff;
      emit         = 1'b0;
      res_byte     = 8'd0;
      res_last     = 1'b0;
      res_empty    = 1'b0;

      if (accept) begin
         case (phase_ff)
            PH_HDR2: begin
               masked_in = in_byte[7];
               if (in_byte[6:0] == LEN16_CODE) begin
                  remaining_in = 64'd0;
                  hdr_count_in = LEN16_BYTES_M1;
                  phase_in     = PH_EXTLEN;
               end else if (in_byte[6:0] == LEN64_CODE) begin
                  remaining_in = 64'd0;
                  hdr_count_in = LEN64_BYTES_M1;
                  phase_in     = PH_EXTLEN;
               end else begin
                  remaining_in = {57'd0, in_byte[6:0]};
                  if (in_byte[7]) begin
                     hdr_count_in = KEY_BYTES_M1;
                     phase_in     = PH_KEY;
                  end else begin
                     // Unmasked frame with a short length: header is complete here.
                     key_index_in = 2'd0;
                     if (in_byte[6:0] == 7'd0) begin
                        emit      = 1'b1;
                        res_last  = 1'b1;
                        res_empty = 1'b1;
                        phase_in  = PH_HDR1;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
            end
            PH_EXTLEN: begin
               remaining_in = ext_len;
               if (hdr_count_ff == 3'd0) begin
                  if (masked_ff) begin
                     hdr_count_in = KEY_BYTES_M1;
                     phase_in     = PH_KEY;
                  end else begin
                     key_index_in = 2'd0;
                     if (ext_len == 64'd0) begin
                        emit      = 1'b1;
                        res_last  = 1'b1;
                        res_empty = 1'b1;
                        phase_in  = PH_HDR1;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end else begin
                  hdr_count_in = hdr_count_ff - 3'd1;
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], in_byte};
               if (hdr_count_ff == 3'd0) begin
                  key_index_in = 2'd0;
                  if (remaining_ff == 64'd0) begin
                     emit      = 1'b1;
                     res_last  = 1'b1;
                     res_empty = 1'b1;
                     phase_in  = PH_HDR1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  hdr_count_in = hdr_count_ff - 3'd1;
               end
            end
            PH_PAYLOAD: begin
               emit         = 1'b1;
               res_byte     = masked_ff ? (in_byte ^ key_byte) : in_byte;
               key_index_in = key_index_ff + 2'd1;
               remaining_in = remaining_ff - 64'd1;
               // The count reaching zero after this byte marks the frame's end.
               if (remaining_ff == 64'd1) begin
                  res_last = 1'b1;
                  phase_in = PH_HDR1;
               end
            end
            default: begin
               // Header byte one; unused phase codes also land here.
               fin_in    = in_byte[7];
               opcode_in = in_byte[3:0];
               phase_in  = PH_HDR2;
            end
         endcase
      end
   end

   always_comb begin
      rsp_word_in.payload_byte  = res_byte;
      rsp_word_in.fin_bit       = fin_ff;
      rsp_word_in.frame_opcode  = opcode_ff;
      rsp_word_in.last_of_frame = res_last;
      rsp_word_in.empty_frame   = res_empty;

      // The output register holds its word until the response side takes it.
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_valid_ff || rsp_chan.ready) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff       <= fin_in;
      opcode_ff    <= opcode_in;
      masked_ff    <= masked_in;
      remaining_ff <= remaining_in;
      hdr_count_ff <= hdr_count_in;
      key_ff       <= key_in;
      key_index_ff <= key_index_in;
      if (emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_word_ff;

   // Reset returns the parser to the first header byte with no word pending.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (phase_ff == PH_HDR1 && !rsp_valid_ff))
      else $error("parser not idle after reset");

   // Every accepted payload byte yields a word in the next cycle.
   a_payload_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_PAYLOAD) |=> rsp_valid_ff)
      else $error("payload byte produced no word");

   // Header byte one always advances to header byte two and produces nothing.
   a_hdr1_advance: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_HDR1) |=> (phase_ff == PH_HDR2 && !$rose(rsp_valid_ff)))
      else $error("header byte one mishandled");

   // An empty-frame word is always the last of its frame and carries a zero byte.
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.empty_frame) |->
         (rsp_word_ff.last_of_frame && rsp_word_ff.payload_byte == 8'd0))
      else $error("malformed empty-frame word");

endmodule

FILE: tb/websocket_frame_deframer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the WebSocket frame deframer: a byte driver, a response
// monitor and a predictor of the frame parser. Depends on wsd_pkg, wsd_if and the RTL.
module websocket_frame_deframer_tb;
   import wsd_pkg::*;

   // How the payload length of a generated frame is encoded on the wire.
   typedef enum int {
      LEN_SHORT,
      LEN_16,
      LEN_64
   } len_form_type;

   localparam int TARGET_BYTES   = 550;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int IDLE_PERCENT   = 30;
   // Bytes in this window of the stream are sent and answered with no idling.
   localparam int STEADY_FIRST   = 250;
   localparam int STEADY_LAST    = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wsd_req_if req_chan ();
   wsd_rsp_if rsp_chan ();

   websocket_frame_deframer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Raw stream bytes waiting to be sent, and the response words that the
   // predictor says must come back, oldest first.
   logic [7:0]   pending_bytes[$];
   rsp_word_type expected_words[$];

   int error_count    = 0;
   int frames_built   = 0;
   int bytes_popped   = 0;
   int bytes_accepted = 0;
   int words_checked  = 0;
   int empty_words    = 0;
   int quiet_cycles   = 0;
   // Index of the byte before which the sender holds until every expected word has come.
   int drain_at       = -1;

   logic steady_stretch;
   assign steady_stretch = (bytes_popped >= STEADY_FIRST) && (bytes_popped < STEADY_LAST);

   // ---------------------------------------------------------------------
   // Parser predictor. Its state starts at the reset values and advances
   // once per byte the block accepts.
   // ---------------------------------------------------------------------
   phase_type   parse_state   = PH_HDR1;
   logic        frame_fin     = 1'b0;
   logic [3:0]  frame_op      = 4'h0;
   logic        frame_masked  = 1'b0;
   logic [63:0] bytes_left    = 64'd0;
   logic [2:0]  header_left   = 3'd0;
   logic [31:0] masking_key   = 32'd0;
   logic [1:0]  key_position  = 2'd0;

   // The header is complete. A zero length ends the frame at once with a single
   // empty word; otherwise the payload follows.
   function automatic bit close_header(output rsp_word_type word);
      word = '0;
      key_position = 2'd0;
      if (bytes_left == 64'd0) begin
         word.fin_bit       = frame_fin;
         word.frame_opcode  = frame_op;
         word.last_of_frame = 1'b1;
         word.empty_frame   = 1'b1;
         parse_state = PH_HDR1;
         return 1'b1;
      end
      parse_state = PH_PAYLOAD;
      return 1'b0;
   endfunction

   // The length is known. Masked frames still carry four key bytes.
   function automatic bit close_length(output rsp_word_type word);
      word = '0;
      if (frame_masked) begin
         header_left = KEY_BYTES_M1;
         parse_state = PH_KEY;
         return 1'b0;
      end
      return close_header(word);
   endfunction

   // Takes one stream byte; returns 1 when the byte gives a response word.
   function automatic bit deframe_byte(input logic [7:0] data, output rsp_word_type word);
      logic [7:0] key_byte;
      bit         produced;
      word     = '0;
      key_byte = 8'h00;
      produced = 1'b0;
      case (parse_state)
         PH_HDR2: begin
            frame_masked = data[7];
            bytes_left   = 64'd0;
            if (data[6:0] == LEN16_CODE) begin
               header_left = LEN16_BYTES_M1;
               parse_state = PH_EXTLEN;
            end else if (data[6:0] == LEN64_CODE) begin
               header_left = LEN64_BYTES_M1;
               parse_state = PH_EXTLEN;
            end else begin
               bytes_left = {57'd0, data[6:0]};
               produced   = close_length(word);
            end
         end
         PH_EXTLEN: begin
            // Big-endian: each new byte shifts in at the bottom.
            bytes_left = {bytes_left[55:0], data};
            if (header_left == 3'd0) begin
               produced = close_length(word);
            end else begin
               header_left = header_left - 3'd1;
            end
         end
         PH_KEY: begin
            masking_key = {masking_key[23:0], data};
            if (header_left == 3'd0) begin
               produced = close_header(word);
            end else begin
               header_left = header_left - 3'd1;
            end
         end
         PH_PAYLOAD: begin
            // The first key byte to arrive masks payload byte 0, 4, 8 and so on.
            if (frame_masked) begin
               key_byte = masking_key[8 * (3 - int'(key_position)) +: 8];
            end
            key_position = key_position + 2'd1;
            bytes_left   = bytes_left - 64'd1;
            word.payload_byte  = data ^ key_byte;
            word.fin_bit       = frame_fin;
            word.frame_opcode  = frame_op;
            word.last_of_frame = (bytes_left == 64'd0);
            if (bytes_left == 64'd0) begin
               parse_state = PH_HDR1;
            end
            produced = 1'b1;
         end
         default: begin
            // Header byte one; the RSV bits are dropped.
            frame_fin   = data[7];
            frame_op    = data[3:0];
            parse_state = PH_HDR2;
         end
      endcase
      return produced;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus building.
   // ---------------------------------------------------------------------

   // Appends one frame to the stream. The body may be shorter than the length
   // field, which leaves the block inside the payload when the stream stops.
   task automatic add_frame(input logic [7:0] first_byte, input bit masked,
                            input len_form_type form, input logic [63:0] length,
                            input logic [31:0] key, input int body_bytes);
      logic [6:0] code;
      code = (form == LEN_16) ? LEN16_CODE : (form == LEN_64) ? LEN64_CODE : length[6:0];
      pending_bytes.push_back(first_byte);
      pending_bytes.push_back({masked, code});
      if (form == LEN_16) begin
         pending_bytes.push_back(length[15:8]);
         pending_bytes.push_back(length[7:0]);
      end else if (form == LEN_64) begin
         for (int i = 7; i >= 0; i--) begin
            pending_bytes.push_back(length[8 * i +: 8]);
         end
      end
      if (masked) begin
         for (int i = 3; i >= 0; i--) begin
            pending_bytes.push_back(key[8 * i +: 8]);
         end
      end
      for (int i = 0; i < body_bytes; i++) begin
         pending_bytes.push_back(8'($urandom_range(255)));
      end
      frames_built++;
   endtask

   // A frame with random header flags, key and encoding. Lengths stay small
   // mostly, with zero lengths, the largest short length and a few long
   // 16-bit frames mixed in. Extended forms also carry non-minimal values.
   task automatic add_random_frame();
      len_form_type form;
      logic [63:0]  length;
      int           pick;
      pick = $urandom_range(99);
      form = (pick < 55) ? LEN_SHORT : (pick < 80) ? LEN_16 : LEN_64;
      pick = $urandom_range(99);
      case (form)
         LEN_SHORT: begin
            if (pick < 10)      length = 64'd0;
            else if (pick < 14) length = 64'd125;
            else                length = 64'($urandom_range(12, 1));
         end
         LEN_16: begin
            if (pick < 10)      length = 64'd0;
            else if (pick < 16) length = 64'($urandom_range(300, 126));
            else                length = 64'($urandom_range(16, 1));
         end
         default: begin
            if (pick < 15)      length = 64'd0;
            else                length = 64'($urandom_range(12, 1));
         end
      endcase
      add_frame(8'($urandom_range(255)), 1'($urandom_range(1)), form, length,
                $urandom, int'(length));
   endtask

   // ---------------------------------------------------------------------
   // Driver: presents the next pending byte unless it idles or holds for
   // the response side to drain; a byte that is not taken stays in place.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type word;
      bit           hold_for_drain;
      bit           idle_now;
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.payload <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            bytes_accepted++;
            if (deframe_byte(req_chan.payload.data_byte, word)) begin
               expected_words.push_back(word);
            end
         end
         if (!req_chan.valid || req_chan.ready) begin
            hold_for_drain = (bytes_popped == drain_at) && (expected_words.size() != 0);
            idle_now = !steady_stretch && ($urandom_range(99) < IDLE_PERCENT);
            if (pending_bytes.size() != 0 && !hold_for_drain && !idle_now) begin
               req_chan.valid   <= 1'b1;
               req_chan.payload <= pending_bytes.pop_front();
               bytes_popped++;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each accepted response word against the oldest
   // expectation, field by field, and throttles ready at random.
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("word %0d %s: got %0h, want %0h",
                                   words_checked, name, got, want));
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("response word %0h with nothing expected", got));
            end else begin
               want = expected_words.pop_front();
               check_field("payload_byte", got.payload_byte, want.payload_byte);
               check_field("fin_bit", 8'(got.fin_bit), 8'(want.fin_bit));
               check_field("frame_opcode", 8'(got.frame_opcode), 8'(want.frame_opcode));
               check_field("last_of_frame", 8'(got.last_of_frame), 8'(want.last_of_frame));
               check_field("empty_frame", 8'(got.empty_frame), 8'(want.empty_frame));
               if (want.empty_frame) begin
                  empty_words++;
               end
            end
            words_checked++;
         end
         rsp_chan.ready <= steady_stretch || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: a correct run never goes this long without a word moving on
   // either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles", quiet_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: build the stream, release reset, wait for the drain.
   // ---------------------------------------------------------------------
   initial begin
      logic [63:0] huge_length;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;

      // Directed frames: an all-zero empty frame; a masked empty frame with
      // every flag, RSV bit and opcode bit set and an all-ones key; a 64-bit
      // extended length of zero, which is empty too; a short masked frame
      // long enough for the key to wrap around.
      add_frame(8'h00, 1'b0, LEN_SHORT, 64'd0, 32'd0, 0);
      add_frame(8'hFF, 1'b1, LEN_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
      add_frame(8'h82, 1'b0, LEN_64, 64'd0, 32'd0, 0);
      add_frame(8'h09, 1'b1, LEN_SHORT, 64'd5, 32'hA53C_0FF0, 5);
      drain_at = pending_bytes.size();

      while (pending_bytes.size() < TARGET_BYTES - 30) begin
         add_random_frame();
      end

      // The stream ends inside a frame whose 64-bit length has its top bit
      // set, so the length is never used up and no word in it is last.
      huge_length = {$urandom, $urandom};
      huge_length[63] = 1'b1;
      add_frame(8'($urandom_range(255)), 1'b1, LEN_64, huge_length, $urandom, 20);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_chan.valid) begin
         @(posedge clock);
      end
      while (expected_words.size() != 0) begin
         @(posedge clock);
      end
      // Wait on past the output register to catch any stray word.
      repeat (10) @(posedge clock);

      $display("Ran %0d frames (%0d bytes) with short, 16-bit and 64-bit lengths,",
               frames_built, bytes_accepted);
      $display("masked and unmasked; checked %0d response words, %0d of them empty.",
               words_checked, empty_words);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: files.f
design/wsd_pkg.sv
design/wsd_if.sv
design/websocket_frame_deframer.sv
tb/websocket_frame_deframer_tb.sv
